/* design/nsc_pkg.sv */
// Shared constants, types and the hex digit decoder for the sentence checksum framer.
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

    // Sentence buffer size in bytes; the last slot ends the sentence as an overflow.
    localparam int BUFFER_BYTES = 128;
    localparam int COUNT_W      = $clog2(BUFFER_BYTES);

    localparam int BYTE_W = 8;
    localparam int POS_W  = 7;
    localparam int ERR_W  = 2;

    // Framing characters.
    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;

    // Shortest sentence position at which a newline can close "$*hh?".
    localparam logic [COUNT_W-1:0] MIN_END_POS = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] LAST_SLOT   = COUNT_W'(BUFFER_BYTES - 1);

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_FORMAT   = 2'd1,
        ERR_SUM      = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    // One verdict per received byte.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              in_sentence;
        logic [POS_W-1:0]  position;
        logic              sentence_end;
        logic              sentence_ok;
        logic [BYTE_W-1:0] sum_received;
        logic [BYTE_W-1:0] sum_computed;
        t_err              error_code;
    } t_verdict;

    // Decodes a hex digit, upper or lower case. Bit 4 is set when the byte is a digit.
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        v = '0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h57;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

`default_nettype wire

/* design/nsc_rx_if.sv */
// Valid/ready channel carrying one received serial byte per beat.
`timescale 1ns / 1ps
`default_nettype none

interface nsc_rx_if;
    logic                      valid;
    logic                      ready;
    logic [nsc_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* design/nsc_verdict_if.sv */
// Valid/ready channel carrying one per-byte framing verdict per beat.
`timescale 1ns / 1ps
`default_nettype none

interface nsc_verdict_if;
    logic                       valid;
    logic                       ready;
    logic [nsc_pkg::BYTE_W-1:0] byte_out;
    logic                       in_sentence;
    logic [nsc_pkg::POS_W-1:0]  position;
    logic                       sentence_end;
    logic                       sentence_ok;
    logic [nsc_pkg::BYTE_W-1:0] sum_received;
    logic [nsc_pkg::BYTE_W-1:0] sum_computed;
    logic [nsc_pkg::ERR_W-1:0]  error_code;

    modport source (output valid, output byte_out, output in_sentence, output position,
                    output sentence_end, output sentence_ok, output sum_received,
                    output sum_computed, output error_code, input ready);
    modport sink   (input valid, input byte_out, input in_sentence, input position,
                    input sentence_end, input sentence_ok, input sum_received,
                    input sum_computed, input error_code, output ready);
endinterface

`default_nettype wire

/* design/nsc_frame_eval.sv */
// Sentence framing state and per-byte verdict logic.
`timescale 1ns / 1ps
`default_nettype none

module nsc_frame_eval (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire logic [nsc_pkg::BYTE_W-1:0] i_byte,
    output nsc_pkg::t_verdict               o_verdict
);

    logic                              r_hunting;
    logic [nsc_pkg::COUNT_W-1:0]       r_count;
    logic [nsc_pkg::BYTE_W-1:0]        r_xor;
    logic [nsc_pkg::BYTE_W-1:0]        r_recent [4];

    logic                              n_hunting;
    logic [nsc_pkg::COUNT_W-1:0]       n_count;
    logic [nsc_pkg::BYTE_W-1:0]        n_xor;
    logic                              n_clear;
    logic                              n_shift;

    logic [4:0]                        hi_dig;
    logic [4:0]                        lo_dig;
    logic [nsc_pkg::BYTE_W-1:0]        comp;
    logic [nsc_pkg::BYTE_W-1:0]        recv;

    // The tail "*hh?" has been folded into the running XOR; take it back out.
    assign comp   = r_xor ^ r_recent[0] ^ r_recent[1] ^ r_recent[2] ^ r_recent[3];
    assign hi_dig = nsc_pkg::hex_decode(r_recent[2]);
    assign lo_dig = nsc_pkg::hex_decode(r_recent[1]);
    assign recv   = {hi_dig[3:0], lo_dig[3:0]};

    // Classify the byte, build its verdict and the next framing state.
    always_comb begin
        o_verdict          = '0;
        o_verdict.byte_out = i_byte;
        o_verdict.error_code = nsc_pkg::ERR_NONE;
        n_hunting          = r_hunting;
        n_count            = r_count;
        n_xor              = r_xor;
        n_clear            = 1'b0;
        n_shift            = 1'b0;

        if (i_byte == nsc_pkg::CH_DOLLAR) begin
            o_verdict.in_sentence = 1'b1;
            n_hunting             = 1'b0;
            n_clear               = 1'b1;
            n_count               = nsc_pkg::COUNT_W'(1);
            n_xor                 = '0;
        end else if (r_hunting) begin
            // Echo only while hunting for the start of a sentence.
        end else if (i_byte == nsc_pkg::CH_NEWLINE) begin
            o_verdict.in_sentence  = 1'b1;
            o_verdict.position     = nsc_pkg::POS_W'(r_count);
            o_verdict.sentence_end = 1'b1;
            if (r_count < nsc_pkg::MIN_END_POS || r_recent[3] != nsc_pkg::CH_STAR) begin
                o_verdict.error_code = nsc_pkg::ERR_FORMAT;
            end else begin
                o_verdict.sum_computed = comp;
                if (!hi_dig[4] || !lo_dig[4]) begin
                    o_verdict.error_code = nsc_pkg::ERR_SUM;
                end else begin
                    o_verdict.sum_received = recv;
                    if (recv == comp) begin
                        o_verdict.sentence_ok = 1'b1;
                    end else begin
                        o_verdict.error_code = nsc_pkg::ERR_SUM;
                    end
                end
            end
            n_hunting = 1'b1;
            n_clear   = 1'b1;
            n_count   = '0;
            n_xor     = '0;
        end else if (r_count >= nsc_pkg::LAST_SLOT) begin
            o_verdict.in_sentence  = 1'b1;
            o_verdict.position     = nsc_pkg::POS_W'(r_count);
            o_verdict.sentence_end = 1'b1;
            o_verdict.error_code   = nsc_pkg::ERR_OVERFLOW;
            n_hunting = 1'b1;
            n_clear   = 1'b1;
            n_count   = '0;
            n_xor     = '0;
        end else begin
            o_verdict.in_sentence = 1'b1;
            o_verdict.position    = nsc_pkg::POS_W'(r_count);
            n_xor                 = r_xor ^ i_byte;
            n_shift               = 1'b1;
            n_count               = r_count + nsc_pkg::COUNT_W'(1);
        end
    end

    // Framing state, updated once per evaluated byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting <= 1'b1;
            r_count   <= '0;
            r_xor     <= '0;
            r_recent  <= '{default: '0};
        end else if (i_advance) begin
            r_hunting <= n_hunting;
            r_count   <= n_count;
            r_xor     <= n_xor;
            if (n_clear) begin
                r_recent <= '{default: '0};
            end else if (n_shift) begin
                r_recent[3] <= r_recent[2];
                r_recent[2] <= r_recent[1];
                r_recent[1] <= r_recent[0];
                r_recent[0] <= i_byte;
            end
        end
    end

    // A closed sentence always sends the framer back to hunting.
    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_verdict.sentence_end |=> r_hunting)
        else $error("framer not hunting after sentence end");

    // The byte count never reaches the buffer size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= nsc_pkg::LAST_SLOT)
        else $error("byte count beyond buffer");

    // While hunting the count stays cleared.
    a_hunt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hunting |-> r_count == '0 && r_xor == '0)
        else $error("frame state not cleared while hunting");

endmodule

`default_nettype wire

/* design/nmea_sentence_checksum_framer_core.sv */
// Top level of the sentence checksum framer: input register, evaluation and result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per beat on i_rx and returns one verdict per byte on o_res, in
// order. A new byte can be taken in every cycle: the block sustains one byte per clock
// while o_res is being drained. An accepted byte is evaluated from the input register and
// its verdict is loaded into the result register when the evaluation stage advances, that
// is when the result register is empty or o_res is taking its beat. The rate is
// set by the single evaluation stage, which updates the sentence state once per byte.
// Each stage holds its beat under back-pressure, so no beat is dropped or repeated.
// A '$' starts or restarts a sentence; a newline closes it and reports the checksum,
// and a byte landing in the last buffer slot closes it with an overflow error.
module nmea_sentence_checksum_framer_core (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    nsc_rx_if.sink         i_rx,
    nsc_verdict_if.source  o_res
);

    logic                        r_in_valid;
    logic [nsc_pkg::BYTE_W-1:0]  r_in_byte;
    logic                        r_out_valid;
    nsc_pkg::t_verdict           r_out;

    logic                        advance;
    nsc_pkg::t_verdict           verdict;

    // The evaluation stage moves when its result has somewhere to go.
    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    nsc_frame_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_verdict (verdict)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= verdict;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.byte_out     = r_out.byte_out;
    assign o_res.in_sentence  = r_out.in_sentence;
    assign o_res.position     = r_out.position;
    assign o_res.sentence_end = r_out.sentence_end;
    assign o_res.sentence_ok  = r_out.sentence_ok;
    assign o_res.sum_received = r_out.sum_received;
    assign o_res.sum_computed = r_out.sum_computed;
    assign o_res.error_code   = r_out.error_code;

    // A sentence end only ever belongs to a sentence.
    a_end_in_sentence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.sentence_end |-> r_out.in_sentence)
        else $error("sentence end outside a sentence");

    // A passing checksum carries no error and equal sums.
    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.sentence_ok |->
            r_out.error_code == nsc_pkg::ERR_NONE &&
            r_out.sum_received == r_out.sum_computed && r_out.sentence_end)
        else $error("sentence ok with error or sum mismatch");

    // Verdict fields are quiet on bytes that close nothing.
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.sentence_end |->
            !r_out.sentence_ok && r_out.sum_received == '0 &&
            r_out.sum_computed == '0 && r_out.error_code == nsc_pkg::ERR_NONE)
        else $error("verdict fields set without sentence end");

endmodule

`default_nettype wire

/* bench/nmea_sentence_checksum_framer_core_tb.sv */
// Self-checking testbench for the sentence checksum framer: directed sentences, then random traffic.
`timescale 1ns / 1ps

module nmea_sentence_checksum_framer_core_tb;

    localparam logic [nsc_pkg::BYTE_W-1:0] CH_CR = 8'h0D;

    // Tail forms of generated sentences.
    typedef enum int {
        TAIL_GOOD,
        TAIL_BAD_SUM,
        TAIL_BAD_HEX,
        TAIL_NO_STAR,
        TAIL_CUT,
        TAIL_NO_CR
    } t_tail;

    // One directed beat, with the verdict typed in where it is obvious.
    typedef struct {
        logic [nsc_pkg::BYTE_W-1:0] rx;
        bit                         typed;
        nsc_pkg::t_verdict          want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    nsc_rx_if      rx_ch ();
    nsc_verdict_if res_ch ();

    nmea_sentence_checksum_framer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    // Framer state as the checker sees it.
    bit                         hunting;
    logic [7:0]                 next_pos;
    logic [nsc_pkg::BYTE_W-1:0] frame_xor;
    logic [nsc_pkg::BYTE_W-1:0] tail_bytes [4];

    nsc_pkg::t_verdict          pending_verdicts [$];
    t_row                       script_rows [$];
    logic [nsc_pkg::BYTE_W-1:0] rx_stream [$];
    int                         mismatches;
    int                         src_idle_pct;
    int                         dst_idle_pct;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #1_000_000;
        $display("nmea_sentence_checksum_framer_core verification failed");
        $finish;
    end

    // Value of a hex digit in either case, or -1 for any other byte.
    function automatic int nibble_of(input logic [nsc_pkg::BYTE_W-1:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic void clear_frame();
        next_pos  = '0;
        frame_xor = '0;
        foreach (tail_bytes[i]) tail_bytes[i] = '0;
    endfunction

    // Advances the framer state by one byte and returns the verdict for it.
    function automatic nsc_pkg::t_verdict frame_byte(input logic [nsc_pkg::BYTE_W-1:0] b);
        nsc_pkg::t_verdict          v;
        logic [7:0]                 at;
        logic [nsc_pkg::BYTE_W-1:0] chk;
        int                         hi_n;
        int                         lo_n;
        v = '0;
        v.byte_out = b;
        at = next_pos;
        if (b == nsc_pkg::CH_DOLLAR) begin
            clear_frame();
            hunting = 1'b0;
            next_pos = 8'd1;
            v.in_sentence = 1'b1;
        end else if (!hunting) begin
            v.in_sentence = 1'b1;
            v.position = at[nsc_pkg::POS_W-1:0];
            if (b == nsc_pkg::CH_NEWLINE) begin
                v.sentence_end = 1'b1;
                if (at < 8'd5 || tail_bytes[3] != nsc_pkg::CH_STAR) begin
                    v.error_code = nsc_pkg::ERR_FORMAT;
                end else begin
                    hi_n = nibble_of(tail_bytes[2]);
                    lo_n = nibble_of(tail_bytes[1]);
                    // The running XOR also holds the star, both digits and the tail byte.
                    chk = frame_xor ^ tail_bytes[0] ^ tail_bytes[1] ^ tail_bytes[2]
                          ^ tail_bytes[3];
                    v.sum_computed = chk;
                    if (hi_n < 0 || lo_n < 0) begin
                        v.error_code = nsc_pkg::ERR_SUM;
                    end else begin
                        v.sum_received = 8'(hi_n * 16 + lo_n);
                        if (v.sum_received == chk) begin
                            v.sentence_ok = 1'b1;
                        end else begin
                            v.error_code = nsc_pkg::ERR_SUM;
                        end
                    end
                end
                hunting = 1'b1;
                clear_frame();
            end else if (int'(at) >= nsc_pkg::BUFFER_BYTES - 1) begin
                // Byte in the last buffer slot: the sentence is dropped as an overflow.
                v.sentence_end = 1'b1;
                v.error_code = nsc_pkg::ERR_OVERFLOW;
                hunting = 1'b1;
                clear_frame();
            end else begin
                frame_xor = frame_xor ^ b;
                tail_bytes[3] = tail_bytes[2];
                tail_bytes[2] = tail_bytes[1];
                tail_bytes[1] = tail_bytes[0];
                tail_bytes[0] = b;
                next_pos = at + 8'd1;
            end
        end
        return v;
    endfunction

    function automatic void add_row(input logic [nsc_pkg::BYTE_W-1:0] b);
        script_rows.push_back('{b, 1'b0, nsc_pkg::t_verdict'('0)});
    endfunction

    function automatic void add_typed(input logic [nsc_pkg::BYTE_W-1:0] b,
                                      input nsc_pkg::t_verdict v);
        script_rows.push_back('{b, 1'b1, v});
    endfunction

    function automatic logic [nsc_pkg::BYTE_W-1:0] body_byte();
        logic [nsc_pkg::BYTE_W-1:0] c;
        do c = 8'($urandom); while (c == nsc_pkg::CH_DOLLAR || c == nsc_pkg::CH_NEWLINE);
        return c;
    endfunction

    function automatic logic [nsc_pkg::BYTE_W-1:0] hex_char(input logic [3:0] n,
                                                            input bit upper);
        if (n < 4'd10) return 8'("0") + 8'(n);
        return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [nsc_pkg::BYTE_W-1:0] non_hex_byte();
        logic [nsc_pkg::BYTE_W-1:0] c;
        do c = body_byte(); while (nibble_of(c) >= 0);
        return c;
    endfunction

    // Queues one sentence with a random body and the given tail form.
    function automatic void queue_sentence(input int body_len, input t_tail form,
                                           input bit restarts);
        logic [nsc_pkg::BYTE_W-1:0] sum;
        logic [nsc_pkg::BYTE_W-1:0] c;
        logic [nsc_pkg::BYTE_W-1:0] hi;
        logic [nsc_pkg::BYTE_W-1:0] lo;
        logic [nsc_pkg::BYTE_W-1:0] star;
        sum = '0;
        rx_stream.push_back(nsc_pkg::CH_DOLLAR);
        for (int i = 0; i < body_len; i++) begin
            if (restarts && $urandom_range(0, 29) == 0) begin
                rx_stream.push_back(nsc_pkg::CH_DOLLAR);
                sum = '0;
            end
            c = body_byte();
            rx_stream.push_back(c);
            sum = sum ^ c;
        end
        if (form == TAIL_CUT) begin
            rx_stream.push_back(nsc_pkg::CH_NEWLINE);
            return;
        end
        if (form == TAIL_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
        hi = hex_char(sum[7:4], 1'($urandom_range(0, 1)));
        lo = hex_char(sum[3:0], 1'($urandom_range(0, 1)));
        if (form == TAIL_BAD_HEX) begin
            if ($urandom_range(0, 1) == 0) hi = non_hex_byte();
            else lo = non_hex_byte();
        end
        star = nsc_pkg::CH_STAR;
        if (form == TAIL_NO_STAR) begin
            do star = body_byte(); while (star == nsc_pkg::CH_STAR);
        end
        rx_stream.push_back(star);
        rx_stream.push_back(hi);
        rx_stream.push_back(lo);
        if (form != TAIL_NO_CR) begin
            rx_stream.push_back(($urandom_range(0, 4) == 0) ? body_byte() : CH_CR);
        end
        rx_stream.push_back(nsc_pkg::CH_NEWLINE);
    endfunction

    function automatic t_tail pick_tail();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return TAIL_GOOD;
        if (r < 70) return TAIL_BAD_SUM;
        if (r < 78) return TAIL_BAD_HEX;
        if (r < 86) return TAIL_NO_STAR;
        if (r < 93) return TAIL_CUT;
        return TAIL_NO_CR;
    endfunction

    // Presents one byte, holds it until the beat is taken and records its verdict.
    task automatic send_byte(input logic [nsc_pkg::BYTE_W-1:0] b, input bit typed,
                             input nsc_pkg::t_verdict v);
        nsc_pkg::t_verdict pred;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom);
            @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        pred = frame_byte(b);
        pending_verdicts.push_back(typed ? v : pred);
    endtask

    task automatic check_field(input string name, input logic [nsc_pkg::BYTE_W-1:0] want,
                               input logic [nsc_pkg::BYTE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Receiver back-pressure.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    // Every verdict beat is matched against the oldest outstanding prediction.
    always @(posedge i_clk) begin : verdict_monitor
        nsc_pkg::t_verdict want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict with no byte outstanding: byte_out 0x%0h", res_ch.byte_out);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("byte_out", want.byte_out, res_ch.byte_out);
                check_field("in_sentence", 8'(want.in_sentence), 8'(res_ch.in_sentence));
                check_field("position", 8'(want.position), 8'(res_ch.position));
                check_field("sentence_end", 8'(want.sentence_end), 8'(res_ch.sentence_end));
                check_field("sentence_ok", 8'(want.sentence_ok), 8'(res_ch.sentence_ok));
                check_field("sum_received", want.sum_received, res_ch.sum_received);
                check_field("sum_computed", want.sum_computed, res_ch.sum_computed);
                check_field("error_code", 8'(want.error_code), 8'(res_ch.error_code));
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int            long_body [2];
        int            short_bytes;
        t_row          row;
        mismatches    = 0;
        src_idle_pct  = 30;
        dst_idle_pct  = 47;
        hunting       = 1'b1;
        clear_frame();
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes while hunting, including a newline, are echoed only.
        add_typed(8'h00, '{8'h00, 1'b0, 7'd0, 1'b0, 1'b0, 8'h00, 8'h00, nsc_pkg::ERR_NONE});
        add_typed(8'hFF, '{8'hFF, 1'b0, 7'd0, 1'b0, 1'b0, 8'h00, 8'h00, nsc_pkg::ERR_NONE});
        add_typed(nsc_pkg::CH_NEWLINE, '{nsc_pkg::CH_NEWLINE, 1'b0, 7'd0, 1'b0, 1'b0,
                                         8'h00, 8'h00, nsc_pkg::ERR_NONE});
        // A sentence closed right after the dollar is too short.
        add_typed(nsc_pkg::CH_DOLLAR, '{nsc_pkg::CH_DOLLAR, 1'b1, 7'd0, 1'b0, 1'b0,
                                        8'h00, 8'h00, nsc_pkg::ERR_NONE});
        add_typed(nsc_pkg::CH_NEWLINE, '{nsc_pkg::CH_NEWLINE, 1'b1, 7'd1, 1'b1, 1'b0,
                                         8'h00, 8'h00, nsc_pkg::ERR_FORMAT});
        // Good sentence with lower-case digits.
        add_row(nsc_pkg::CH_DOLLAR); add_row("z"); add_row(nsc_pkg::CH_STAR);
        add_row("7"); add_row("a"); add_row(CH_CR);
        add_typed(nsc_pkg::CH_NEWLINE, '{nsc_pkg::CH_NEWLINE, 1'b1, 7'd6, 1'b1, 1'b1,
                                         8'h7A, 8'h7A, nsc_pkg::ERR_NONE});
        // Mismatching sum in upper case.
        add_row(nsc_pkg::CH_DOLLAR); add_row("z"); add_row(nsc_pkg::CH_STAR);
        add_row("7"); add_row("B"); add_row(CH_CR);
        add_typed(nsc_pkg::CH_NEWLINE, '{nsc_pkg::CH_NEWLINE, 1'b1, 7'd6, 1'b1, 1'b0,
                                         8'h7B, 8'h7A, nsc_pkg::ERR_SUM});
        // Restart inside a sentence, a non-hex digit, and a tail byte that is not CR.
        add_row(nsc_pkg::CH_DOLLAR); add_row(nsc_pkg::CH_DOLLAR); add_row("z");
        add_row(nsc_pkg::CH_STAR); add_row("g"); add_row("1"); add_row(8'hFF);
        add_typed(nsc_pkg::CH_NEWLINE, '{nsc_pkg::CH_NEWLINE, 1'b1, 7'd6, 1'b1, 1'b0,
                                         8'h00, 8'h7A, nsc_pkg::ERR_SUM});

        foreach (script_rows[i]) begin
            row = script_rows[i];
            send_byte(row.rx, row.typed, row.want);
        end

        // Random traffic in three phases, the third without idling. The first two open with a long
        // sentence: one overflows on its star, the other closes at the last slot.
        long_body[0] = nsc_pkg::BUFFER_BYTES - 2;
        long_body[1] = nsc_pkg::BUFFER_BYTES - 6;
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 47 : 0;
            dst_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 30 : 0;
            if (phase < 2) queue_sentence(long_body[phase], TAIL_GOOD, 1'b0);
            short_bytes = rx_stream.size() + 35;
            while (rx_stream.size() < short_bytes) begin
                if ($urandom_range(0, 99) < 10) begin
                    // Line noise, any byte value.
                    repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom));
                end else begin
                    queue_sentence($urandom_range(0, 14), pick_tail(), 1'b1);
                end
            end
            while (rx_stream.size() != 0) send_byte(rx_stream.pop_front(), 1'b0, '0);
        end

        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("nmea_sentence_checksum_framer_core verification clean");
        end else begin
            $display("nmea_sentence_checksum_framer_core verification failed");
        end
        $finish;
    end

endmodule
